// ===== hdl/sgrf_pkg.sv =====
// Shared types and constants for the separable Gaussian RGB filter.
// Holds the beat payload structs, register indexes, mode codes and FSM states.
// No dependencies.
package sgrf_pkg;

  localparam int MAX_RADIUS_DEFAULT = 3;
  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int COEF_BITS_DEFAULT  = 16;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH        = 3'd0,
    CFG_IMAGE_HEIGHT       = 3'd1,
    CFG_RADIUS             = 3'd2,
    CFG_BOUNDARY_MODE      = 3'd3,
    CFG_HORIZONTAL_WEIGHTS = 3'd4,
    CFG_VERTICAL_WEIGHTS   = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    BM_ZERO_PAD = 2'd0,
    BM_MIRROR   = 2'd1,
    BM_ADJUST   = 2'd2
  } boundary_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP_ADDR,
    ST_TAP_MAC,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        frame_last;
  } out_item_t;

endpackage

// ===== hdl/separable_gaussian_rgb_filter.sv =====
// Separable Gaussian filter on an RGB raster stream, top level.
// Depends on sgrf_pkg for payload structs, register indexes and states.
//
// Usage: pixels enter in raster order on the input channel (valid/stall);
// mode 1 beats are drain ticks that push out the pixels left after the
// frame's last pixel. Each filtered pixel leaves on the output channel as one
// beat with its row and column; frame_last marks the last pixel of a frame.
// Geometry, boundary mode and the Q0.16 weight sets are written through the
// plain write port while the block is idle; a geometry write restarts the
// frame.
// Work per beat: a beat that produces no result is taken in the idle state.
// A beat that produces a result stalls the input while the block walks all
// (2n+1)^2 taps (n = radius), divides in the adjust-kernel mode, and loads
// the result into the output register. Every tap is one read
// of the single-port line memory followed by one multiply-accumulate step;
// the adjust mode then runs a bit-serial divider for one quotient bit a cycle.
// The result sits in an output register, so a stalled receiver does not hold
// up the input until the next result is ready to be loaded.
// Reset clears the counters and restores the register defaults; the line
// memory is not cleared, and no in-bound tap reads an entry not written this frame.
module separable_gaussian_rgb_filter #(
  parameter int MAX_RADIUS = sgrf_pkg::MAX_RADIUS_DEFAULT,
  parameter int MAX_WIDTH  = sgrf_pkg::MAX_WIDTH_DEFAULT,
  parameter int COEF_BITS  = sgrf_pkg::COEF_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sgrf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sgrf_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int RB        = $clog2(2 * MAX_RADIUS + 2);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int AW        = RB + CW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int WLIM      = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int WP_W      = 2 * COEF_BITS;
  localparam int PROD_W    = WP_W + 8;
  localparam int ACC_W     = WP_W + 14;
  localparam int WS_W      = WP_W + 6;
  localparam int LIN_W     = 23;

  // Configuration registers.
  logic [11:0] width_q, height_q;
  logic [1:0]  radius_q, bmode_q;
  logic [63:0] hw_q, vw_q;

  // Stream counters.
  logic [10:0]      in_row_q, in_col_q, emit_row_q, emit_col_q;
  logic [LIN_W-1:0] lin_in_q, lin_emit_q;
  logic             frame_done_q;

  sgrf_pkg::state_e state_q, state_d;

  logic signed [2:0] ta_q, tb_q;
  logic              inb_q;
  logic [WP_W-1:0]   wt_q;
  logic [ACC_W-1:0]  acc_q [3];
  logic [WS_W-1:0]   wsum_q;
  logic [ACC_W-1:0]  dv_q;
  logic [3:0]        div_cnt_q;
  logic [2:0]        sat_q;
  logic [7:0]        quo_q [3];

  logic                out_valid_q;
  sgrf_pkg::out_item_t out_q;

  logic [23:0] mem [MEM_DEPTH];
  logic [23:0] rd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  // Effective geometry.
  logic [11:0] w_eff, h_eff;
  logic [1:0]  n_eff;
  logic signed [2:0] n_s;
  logic signed [12:0] lastr_s, lastc_s;
  logic [LIN_W-1:0] lag;

  always_comb begin
    if (width_q == 12'd0) begin
      w_eff = 12'd1;
    end else if (width_q > 12'(WLIM)) begin
      w_eff = 12'(WLIM);
    end else begin
      w_eff = width_q;
    end
    if (height_q == 12'd0) begin
      h_eff = 12'd1;
    end else if (height_q > 12'd2048) begin
      h_eff = 12'd2048;
    end else begin
      h_eff = height_q;
    end
    if (radius_q == 2'd0) begin
      n_eff = 2'd1;
    end else if (radius_q > 2'(MAX_RADIUS)) begin
      n_eff = 2'(MAX_RADIUS);
    end else begin
      n_eff = radius_q;
    end
    n_s     = $signed({1'b0, n_eff});
    lastr_s = $signed({1'b0, h_eff - 12'd1});
    lastc_s = $signed({1'b0, w_eff - 12'd1});
    lag     = LIN_W'(n_eff) * LIN_W'(w_eff) + LIN_W'(n_eff);
  end

  // Input side: counters as seen after an end-of-frame restart.
  logic             in_fire, is_pixel, emit_go;
  logic [10:0]      in_row_cur, in_col_cur;
  logic [LIN_W-1:0] lin_in_cur, lin_emit_cur;
  logic [11:0]      col_inc, row_inc;

  always_comb begin
    in_fire      = in_valid_i && !in_stall_o;
    is_pixel     = (in_data_i.mode == sgrf_pkg::MODE_PIXEL);
    in_row_cur   = frame_done_q ? 11'd0 : in_row_q;
    in_col_cur   = frame_done_q ? 11'd0 : in_col_q;
    lin_in_cur   = frame_done_q ? '0 : lin_in_q;
    lin_emit_cur = frame_done_q ? '0 : lin_emit_q;
    col_inc      = {1'b0, in_col_cur} + 12'd1;
    row_inc      = {1'b0, in_row_cur} + 12'd1;
    if (is_pixel) begin
      emit_go = (lin_emit_cur + lag) <= lin_in_cur;
    end else begin
      emit_go = frame_done_q;
    end
    wr_addr = {in_row_cur[RB-1:0], CW'(in_col_cur)};
  end

  // Tap geometry and weight.
  function automatic logic signed [12:0] reflect(input logic signed [12:0] p,
                                                 input logic signed [12:0] last);
    logic signed [12:0] r;
    r = p;
    if (r > last) begin
      r = (last <<< 1) - r;
    end else if (r < 0) begin
      r = -r;
    end
    if (r < 0) begin
      r = 13'sd0;
    end
    if (r > last) begin
      r = last;
    end
    return r;
  endfunction

  logic signed [12:0] rr, cc, rr_use, cc_use;
  logic               tap_inb, tap_last;
  logic [1:0]         kv, kh;
  logic [COEF_BITS-1:0] vwt, hwt;
  logic [WP_W-1:0]    tap_wt;

  always_comb begin
    rr = $signed({2'b00, emit_row_q}) + 13'(ta_q);
    cc = $signed({2'b00, emit_col_q}) + 13'(tb_q);
    if (bmode_q == sgrf_pkg::BM_MIRROR) begin
      rr_use  = reflect(rr, lastr_s);
      cc_use  = reflect(cc, lastc_s);
      tap_inb = 1'b1;
    end else begin
      rr_use  = rr;
      cc_use  = cc;
      tap_inb = (rr >= 0) && (rr <= lastr_s) && (cc >= 0) && (cc <= lastc_s);
    end
    rd_addr  = {rr_use[RB-1:0], CW'($unsigned(cc_use))};
    kv       = ta_q[2] ? 2'(-ta_q) : ta_q[1:0];
    kh       = tb_q[2] ? 2'(-tb_q) : tb_q[1:0];
    vwt      = vw_q[{kv, 4'b0000} +: COEF_BITS];
    hwt      = hw_q[{kh, 4'b0000} +: COEF_BITS];
    tap_wt   = WP_W'(vwt) * WP_W'(hwt);
    tap_last = (ta_q == n_s) && (tb_q == n_s);
  end

  // Divider step: the first step only checks for saturation.
  logic [ACC_W-1:0] dv_cur;
  logic [2:0]       ge;

  always_comb begin
    dv_cur = (div_cnt_q == 4'd0) ? (ACC_W'(wsum_q) << 8) : dv_q;
    for (int ch = 0; ch < 3; ch++) begin
      ge[ch] = acc_q[ch] >= dv_cur;
    end
  end

  // Final channel values and the outgoing beat.
  logic                out_free, is_last;
  logic [7:0]          chv [3];
  sgrf_pkg::out_item_t res;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    is_last  = ({1'b0, emit_row_q} == h_eff - 12'd1) &&
               ({1'b0, emit_col_q} == w_eff - 12'd1);
    for (int ch = 0; ch < 3; ch++) begin
      if (bmode_q == sgrf_pkg::BM_ADJUST) begin
        if (wsum_q == '0) begin
          chv[ch] = 8'd0;
        end else if (sat_q[ch]) begin
          chv[ch] = 8'd255;
        end else begin
          chv[ch] = quo_q[ch];
        end
      end else if (|acc_q[ch][ACC_W-1:WP_W+8]) begin
        chv[ch] = 8'd255;
      end else begin
        chv[ch] = acc_q[ch][WP_W +: 8];
      end
    end
    res.out_row    = emit_row_q;
    res.out_col    = emit_col_q;
    res.out_red    = chv[0];
    res.out_green  = chv[1];
    res.out_blue   = chv[2];
    res.frame_last = is_last;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgrf_pkg::ST_IDLE: begin
        if (in_fire && emit_go) begin
          state_d = sgrf_pkg::ST_TAP_ADDR;
        end
      end
      sgrf_pkg::ST_TAP_ADDR: state_d = sgrf_pkg::ST_TAP_MAC;
      sgrf_pkg::ST_TAP_MAC: begin
        if (!tap_last) begin
          state_d = sgrf_pkg::ST_TAP_ADDR;
        end else if (bmode_q == sgrf_pkg::BM_ADJUST) begin
          state_d = sgrf_pkg::ST_DIV;
        end else begin
          state_d = sgrf_pkg::ST_RESULT;
        end
      end
      sgrf_pkg::ST_DIV: begin
        if (div_cnt_q == 4'd8) begin
          state_d = sgrf_pkg::ST_RESULT;
        end
      end
      sgrf_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = sgrf_pkg::ST_IDLE;
        end
      end
      default: state_d = sgrf_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = (state_q != sgrf_pkg::ST_IDLE);
    mem_we     = (state_q == sgrf_pkg::ST_IDLE) && in_fire && is_pixel;
    mem_re     = (state_q == sgrf_pkg::ST_TAP_ADDR);
  end

  // Line memory: the input write and the tap reads never share a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {in_data_i.blue, in_data_i.green, in_data_i.red};
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgrf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= 12'd512;
      height_q     <= 12'd512;
      radius_q     <= 2'd1;
      bmode_q      <= sgrf_pkg::BM_ZERO_PAD;
      hw_q         <= 64'd1177187248;
      vw_q         <= 64'd1177187248;
      in_row_q     <= '0;
      in_col_q     <= '0;
      emit_row_q   <= '0;
      emit_col_q   <= '0;
      lin_in_q     <= '0;
      lin_emit_q   <= '0;
      frame_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      ta_q         <= '0;
      tb_q         <= '0;
      inb_q        <= 1'b0;
      wt_q         <= '0;
      wsum_q       <= '0;
      dv_q         <= '0;
      div_cnt_q    <= '0;
      sat_q        <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc_q[ch] <= '0;
        quo_q[ch] <= '0;
      end
    end else begin
      if (state_q == sgrf_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        sgrf_pkg::ST_IDLE: begin
          if (in_fire && is_pixel) begin
            if (frame_done_q) begin
              emit_row_q <= '0;
              emit_col_q <= '0;
              lin_emit_q <= '0;
            end
            lin_in_q <= lin_in_cur + LIN_W'(1);
            if (col_inc >= w_eff) begin
              in_col_q <= '0;
              if (row_inc >= h_eff) begin
                in_row_q     <= '0;
                frame_done_q <= 1'b1;
              end else begin
                in_row_q     <= row_inc[10:0];
                frame_done_q <= 1'b0;
              end
            end else begin
              in_col_q     <= col_inc[10:0];
              in_row_q     <= in_row_cur;
              frame_done_q <= 1'b0;
            end
          end
          if (in_fire && emit_go) begin
            ta_q   <= -n_s;
            tb_q   <= -n_s;
            wsum_q <= '0;
            for (int ch = 0; ch < 3; ch++) begin
              acc_q[ch] <= '0;
            end
          end
        end
        sgrf_pkg::ST_TAP_ADDR: begin
          inb_q <= tap_inb;
          wt_q  <= tap_wt;
        end
        sgrf_pkg::ST_TAP_MAC: begin
          if (inb_q) begin
            wsum_q <= wsum_q + WS_W'(wt_q);
            for (int ch = 0; ch < 3; ch++) begin
              acc_q[ch] <= acc_q[ch] +
                           ACC_W'(PROD_W'(wt_q) * PROD_W'(rd_q[8*ch +: 8]));
            end
          end
          if (tb_q == n_s) begin
            tb_q <= -n_s;
            ta_q <= ta_q + 3'sd1;
          end else begin
            tb_q <= tb_q + 3'sd1;
          end
          div_cnt_q <= '0;
        end
        sgrf_pkg::ST_DIV: begin
          dv_q      <= dv_cur >> 1;
          div_cnt_q <= div_cnt_q + 4'd1;
          for (int ch = 0; ch < 3; ch++) begin
            if (div_cnt_q == 4'd0) begin
              sat_q[ch] <= ge[ch];
              quo_q[ch] <= '0;
            end else begin
              if (ge[ch]) begin
                acc_q[ch] <= acc_q[ch] - dv_cur;
              end
              quo_q[ch] <= {quo_q[ch][6:0], ge[ch]};
            end
          end
        end
        sgrf_pkg::ST_RESULT: begin
          if (out_free) begin
            out_q <= res;
            if (is_last) begin
              in_row_q     <= '0;
              in_col_q     <= '0;
              emit_row_q   <= '0;
              emit_col_q   <= '0;
              lin_in_q     <= '0;
              lin_emit_q   <= '0;
              frame_done_q <= 1'b0;
            end else begin
              lin_emit_q <= lin_emit_q + LIN_W'(1);
              if (({1'b0, emit_col_q} + 12'd1) >= w_eff) begin
                emit_col_q <= '0;
                emit_row_q <= emit_row_q + 11'd1;
              end else begin
                emit_col_q <= emit_col_q + 11'd1;
              end
            end
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        case (cfg_index_i)
          sgrf_pkg::CFG_IMAGE_WIDTH:        width_q  <= cfg_data_i[11:0];
          sgrf_pkg::CFG_IMAGE_HEIGHT:       height_q <= cfg_data_i[11:0];
          sgrf_pkg::CFG_RADIUS:             radius_q <= cfg_data_i[1:0];
          sgrf_pkg::CFG_BOUNDARY_MODE:      bmode_q  <= cfg_data_i[1:0];
          sgrf_pkg::CFG_HORIZONTAL_WEIGHTS: hw_q     <= cfg_data_i;
          sgrf_pkg::CFG_VERTICAL_WEIGHTS:   vw_q     <= cfg_data_i;
          default: ;
        endcase
        // A geometry change starts a new frame.
        if (cfg_index_i == sgrf_pkg::CFG_IMAGE_WIDTH ||
            cfg_index_i == sgrf_pkg::CFG_IMAGE_HEIGHT ||
            cfg_index_i == sgrf_pkg::CFG_RADIUS) begin
          in_row_q     <= '0;
          in_col_q     <= '0;
          emit_row_q   <= '0;
          emit_col_q   <= '0;
          lin_in_q     <= '0;
          lin_emit_q   <= '0;
          frame_done_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/sgrf_checker.sv =====
// Port-level checks for the separable Gaussian RGB filter.
// Depends on sgrf_pkg; bound to the top level at the end of this file.
module sgrf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sgrf_pkg::out_item_t out_data_o
);

  // A stalled output beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // The block only starts work on an accepted input beat.
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i |=> !in_stall_o)
    else $error("input stalled without an accepted beat");

  // A new result is loaded only while an item is being worked on.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind separable_gaussian_rgb_filter sgrf_checker u_sgrf_checker (.*);
